[src/shs_pkg.sv]
package shs_pkg;

  // One input transfer: absorb a byte or finalize.
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } msg_t;

  // One output transfer: a digest word.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  // Command codes
  localparam logic CMD_ABSORB   = 1'b0;
  localparam logic CMD_FINALIZE = 1'b1;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [3:0] LEN_HI_WORD = 4'd14;
  localparam logic [3:0] LEN_LO_WORD = 4'd15;
  localparam logic [5:0] LAST_FILL   = 6'h3f;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [2:0] LAST_WORD   = 3'd7;
  // Hash memory sweeps: 8 reads, the last read data arriving from a registered port.
  localparam logic [3:0] SWEEP_LAST  = 4'd8;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic       shift;  // shift working vars by one word
    logic       load;   // shift in the hash word (else rotate)
    logic       round;  // run one compression round
    logic [5:0] rnd;    // round number
  } rctl_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h;
    case (idx)
      3'd0:    h = 32'h6a09e667;
      3'd1:    h = 32'hbb67ae85;
      3'd2:    h = 32'h3c6ef372;
      3'd3:    h = 32'ha54ff53a;
      3'd4:    h = 32'h510e527f;
      3'd5:    h = 32'h9b05688c;
      3'd6:    h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[src/shs_round.sv]
// Working variables a..h, rolling 16-word message schedule, one round per cycle while ctl.round is set.
module shs_round (
  input  logic              clk,
  input  shs_pkg::rctl_t    ctl,
  input  logic [31:0]       hash_word,
  input  logic [31:0]       blk_word,
  output logic [31:0]       head_word
);

  logic [31:0] v [8];
  logic [31:0] sched [16];  // sched[15] newest
  logic [31:0] w_reg;       // schedule word precomputed for next round
  logic [31:0] w_cur;
  logic [31:0] w_next;
  logic [31:0] big_s0;
  logic [31:0] big_s1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] sig0;
  logic [31:0] sig1;

  always_comb begin
    // rounds 0..15 take block words straight from memory
    w_cur  = (ctl.rnd[5:4] == 2'b00) ? blk_word : w_reg;
    big_s1 = shs_pkg::rotr32(v[4], 6) ^ shs_pkg::rotr32(v[4], 11) ^ shs_pkg::rotr32(v[4], 25);
    ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1     = v[7] + big_s1 + ch + shs_pkg::ROUND_K[ctl.rnd] + w_cur;
    big_s0 = shs_pkg::rotr32(v[0], 2) ^ shs_pkg::rotr32(v[0], 13) ^ shs_pkg::rotr32(v[0], 22);
    maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2     = big_s0 + maj;
    // w[t+1] from w[t-1], w[t-6], w[t-14], w[t-15]
    sig1   = shs_pkg::rotr32(sched[15], 17) ^ shs_pkg::rotr32(sched[15], 19) ^ (sched[15] >> 10);
    sig0   = shs_pkg::rotr32(sched[2], 7) ^ shs_pkg::rotr32(sched[2], 18) ^ (sched[2] >> 3);
    w_next = sig1 + sched[10] + sig0 + sched[1];
  end

  always_ff @(posedge clk) begin
    if (ctl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int k = 0; k < 15; k++) sched[k] <= sched[k+1];
      sched[15] <= w_cur;
      w_reg     <= w_next;
    end else if (ctl.shift) begin
      for (int k = 0; k < 7; k++) v[k] <= v[k+1];
      v[7] <= ctl.load ? hash_word : v[0];
    end
  end

  assign head_word = v[0];

endmodule

[src/sha256_stream_hasher_core.sv]
// Channel | Direction | Handshake                   | Payload
// msg     | in        | msg_valid / msg_stall       | shs_pkg::msg_t    (cmd, data_byte)
// digest  | out       | digest_valid / digest_stall | shs_pkg::digest_t (word, index, last)
//
// Absorb: a block-filling byte starts a compression (hash load, 64 rounds, fold). Finalize:
// pad words fill/4..15 and a compression, a second pad block and compression if 56+ bytes
// are buffered, then 8 words off the hash memory port. rst is synchronous and clears control
// and the hash valid bits: the hash memory reads as the initial values with no clearing pass.
// msg_stall is high while the sequencer is busy; digest_stall holds the output register and
// S_OUT_RD, and bytes are taken while the last word waits.
module sha256_stream_hasher_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_stall,
  input  shs_pkg::msg_t     msg,
  output logic              digest_valid,
  input  logic              digest_stall,
  output shs_pkg::digest_t  digest
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PAD    = 7'b0000010,
    S_LOAD   = 7'b0000100,
    S_ROUND  = 7'b0001000,
    S_FOLD   = 7'b0010000,
    S_OUT_RD = 7'b0100000,
    S_OUT_LD = 7'b1000000
  } state_t;

  state_t st, st_next;

  logic [5:0]  fill;        // bytes in the block buffer
  logic [63:0] bitlen;      // message length in bits, wraps
  logic [23:0] pack;        // bytes of the partial word
  logic [3:0]  cnt;         // hash memory sweep counter
  logic [5:0]  rnd;
  logic [2:0]  oi;          // digest word being sent
  logic [3:0]  pw;          // padding word address
  logic        first_pend;  // next padding word carries the 0x80 byte
  logic        extra;       // length goes in a second padding block
  logic        final_blk;   // this compression ends the message

  logic msg_acc;
  logic dig_take;

  // block buffer: 16 words
  logic [31:0] blk_mem [16];
  logic        blk_we;
  logic [3:0]  blk_wa;
  logic [31:0] blk_wd;
  logic [3:0]  blk_ra;
  logic [31:0] blk_q;
  logic [31:0] first_word;
  logic [31:0] pad_word;

  // hash words: 8 entries, valid bits make an unwritten entry read as the IV
  logic [31:0] hash_mem [8];
  logic [7:0]  hvalid;
  logic [2:0]  ha;
  logic [2:0]  ha_q;
  logic        hv_q;
  logic [31:0] hq;
  logic [31:0] hash_rd;
  logic        hash_we;
  logic [2:0]  hash_wa;
  logic [31:0] hash_wd;
  logic        finish;

  shs_pkg::rctl_t rctl;
  logic [31:0]    head_word;

  assign msg_stall = (st != S_IDLE);
  assign msg_acc   = msg_valid && !msg_stall;
  assign dig_take  = digest_valid && !digest_stall;
  assign finish    = (st == S_OUT_LD) && (oi == shs_pkg::LAST_WORD);

  // ---------------- padding words ----------------
  always_comb begin
    case (fill[1:0])
      2'd1:    first_word = {pack[7:0], shs_pkg::PAD_BYTE, 16'h0};
      2'd2:    first_word = {pack[15:0], shs_pkg::PAD_BYTE, 8'h0};
      2'd3:    first_word = {pack[23:0], shs_pkg::PAD_BYTE};
      default: first_word = {shs_pkg::PAD_BYTE, 24'h0};
    endcase
    if (first_pend) begin
      pad_word = first_word;
    end else if (!extra && pw == shs_pkg::LEN_HI_WORD) begin
      pad_word = bitlen[63:32];
    end else if (!extra && pw == shs_pkg::LEN_LO_WORD) begin
      pad_word = bitlen[31:0];
    end else begin
      pad_word = '0;
    end
  end

  // ---------------- block buffer port ----------------
  always_comb begin
    blk_we = 1'b0;
    blk_wa = fill[5:2];
    blk_wd = {pack, msg.data_byte};
    if (msg_acc && msg.cmd == shs_pkg::CMD_ABSORB && fill[1:0] == 2'b11) begin
      blk_we = 1'b1;
    end
    if (st == S_PAD) begin
      blk_we = 1'b1;
      blk_wa = pw;
      blk_wd = pad_word;
    end
    // prefetch the word for the next round; word 0 during the hash load
    blk_ra = (st == S_ROUND) ? rnd[3:0] + 4'd1 : '0;
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_wa] <= blk_wd;
    end
    blk_q <= blk_mem[blk_ra];
  end

  // ---------------- hash memory port ----------------
  always_comb begin
    ha      = (st == S_OUT_RD || st == S_OUT_LD) ? oi : cnt[2:0];
    hash_rd = hv_q ? hq : shs_pkg::init_h(ha_q);
    // fold: word cnt-1 arrives now, add its working var and write back
    hash_we = (st == S_FOLD) && (cnt != '0);
    hash_wa = cnt[2:0] - 3'd1;
    hash_wd = hash_rd + head_word;
  end

  always_ff @(posedge clk) begin
    if (hash_we) begin
      hash_mem[hash_wa] <= hash_wd;
    end
    hq   <= hash_mem[ha];
    ha_q <= ha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
      hv_q   <= 1'b0;
    end else begin
      hv_q <= hvalid[ha];
      if (finish) begin
        hvalid <= '0;
      end else if (hash_we) begin
        hvalid[hash_wa] <= 1'b1;
      end
    end
  end

  // ---------------- round datapath ----------------
  always_comb begin
    rctl.shift = ((st == S_LOAD) || (st == S_FOLD)) && (cnt != '0);
    rctl.load  = (st == S_LOAD);
    rctl.round = (st == S_ROUND);
    rctl.rnd   = rnd;
  end

  shs_round u_round (
    .clk       (clk),
    .ctl       (rctl),
    .hash_word (hash_rd),
    .blk_word  (blk_q),
    .head_word (head_word)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (msg_acc) begin
          if (msg.cmd == shs_pkg::CMD_FINALIZE) begin
            st_next = S_PAD;
          end else if (fill == shs_pkg::LAST_FILL) begin
            st_next = S_LOAD;
          end
        end
      end
      S_PAD: begin
        if (pw == shs_pkg::LEN_LO_WORD) st_next = S_LOAD;
      end
      S_LOAD: begin
        if (cnt == shs_pkg::SWEEP_LAST) st_next = S_ROUND;
      end
      S_ROUND: begin
        if (rnd == shs_pkg::LAST_ROUND) st_next = S_FOLD;
      end
      S_FOLD: begin
        if (cnt == shs_pkg::SWEEP_LAST) begin
          if (extra) begin
            st_next = S_PAD;
          end else if (final_blk) begin
            st_next = S_OUT_RD;
          end else begin
            st_next = S_IDLE;
          end
        end
      end
      S_OUT_RD: begin
        // output register is free by the time the read data lands
        if (!digest_valid || dig_take) st_next = S_OUT_LD;
      end
      S_OUT_LD: begin
        st_next = (oi == shs_pkg::LAST_WORD) ? S_IDLE : S_OUT_RD;
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      fill         <= '0;
      bitlen       <= '0;
      cnt          <= '0;
      rnd          <= '0;
      oi           <= '0;
      pw           <= '0;
      first_pend   <= 1'b0;
      extra        <= 1'b0;
      final_blk    <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      st  <= st_next;
      cnt <= ((st == S_LOAD || st == S_FOLD) && st_next == st) ? cnt + 4'd1 : '0;
      rnd <= (st == S_ROUND) ? rnd + 6'd1 : '0;

      if (msg_acc) begin
        if (msg.cmd == shs_pkg::CMD_FINALIZE) begin
          pw         <= fill[5:2];
          first_pend <= 1'b1;
          extra      <= (fill[5:2] >= shs_pkg::LEN_HI_WORD);
          final_blk  <= 1'b1;
        end else begin
          fill      <= fill + 6'd1;
          bitlen    <= bitlen + 64'd8;
          final_blk <= 1'b0;
        end
      end

      if (st == S_PAD) begin
        pw         <= pw + 4'd1;
        first_pend <= 1'b0;
      end

      if (st == S_FOLD && cnt == shs_pkg::SWEEP_LAST && extra) begin
        extra <= 1'b0;
        pw    <= '0;
      end

      if (st == S_OUT_LD) begin
        oi <= oi + 3'd1;
      end

      if (finish) begin
        fill   <= '0;
        bitlen <= '0;
      end

      if (st == S_OUT_LD) begin
        digest_valid <= 1'b1;
      end else if (dig_take) begin
        digest_valid <= 1'b0;
      end
    end
  end

  // partial word and output payload
  always_ff @(posedge clk) begin
    if (msg_acc && msg.cmd == shs_pkg::CMD_ABSORB) begin
      pack <= {pack[15:0], msg.data_byte};
    end
    if (st == S_OUT_LD) begin
      digest.digest_word <= hash_rd;
      digest.word_index  <= oi;
      digest.last_word   <= (oi == shs_pkg::LAST_WORD);
    end
  end

`ifndef SYNTHESIS
  a_round_step: assert property (@(posedge clk) disable iff (rst)
    (st == S_ROUND && rnd != shs_pkg::LAST_ROUND) |=>
      (st == S_ROUND && rnd == $past(rnd) + 6'd1))
    else $error("round counter skipped");

  a_no_blk_write_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (st == S_ROUND) |-> !blk_we)
    else $error("block buffer written during compression");

  a_out_reg_free: assert property (@(posedge clk) disable iff (rst)
    (st == S_OUT_LD) |-> !digest_valid)
    else $error("digest word overwritten before transfer");

  a_pad_to_load: assert property (@(posedge clk) disable iff (rst)
    (st == S_PAD && pw == shs_pkg::LEN_LO_WORD) |=> (st == S_LOAD && cnt == '0))
    else $error("padding did not start compression");
`endif

endmodule
